### sv/rcpe_pkg.sv
// shared types, constants and the notify lookup for the rectangle pair engine
// no dependencies

package rcpe_pkg;

    localparam int SLOTS   = 8;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int KINDS   = 5;
    localparam int ALLOW_W = KINDS * KINDS;
    localparam logic [ALLOW_W-1:0] ALLOW_RESET = ALLOW_W'(11152000);

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 8;

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_MARK  = 2'd1,
        FUNC_SCAN  = 2'd2,
        FUNC_CLEAR = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        CODE_ADDED   = 3'd0,
        CODE_FULL    = 3'd1,
        CODE_MARKED  = 3'd2,
        CODE_PAIR    = 3'd3,
        CODE_DONE    = 3'd4,
        CODE_CLEARED = 3'd5,
        CODE_EMPTY   = 3'd6
    } t_code;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND_I,
        S_LOAD_A,
        S_FIND_K,
        S_CMP,
        S_EMIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        cb;
        logic [2:0]  kind;
        logic [14:0] height;
        logic [14:0] width;
        logic [15:0] top;
        logic [15:0] left;
    } t_entry;

    // receiver side notify flag from own tag, other tag and the permission mask
    function automatic logic notify(input logic [3:0] self_tag,
                                    input logic [3:0] other_tag,
                                    input logic [ALLOW_W-1:0] mask);
        logic [2:0] sk;
        logic [2:0] ok;
        logic [4:0] idx;
        sk  = self_tag[2:0];
        ok  = other_tag[2:0];
        idx = 5'(sk) * 5'(KINDS) + 5'(ok);
        if (!self_tag[3] || sk > 3'(KINDS - 1) || ok > 3'(KINDS - 1)) begin
            return 1'b0;
        end
        return mask[idx];
    endfunction

endpackage

### sv/rect_collision_pair_engine_top.sv
// rectangle slot table with add, mark, clear and an all-pairs overlap scan
// depends on rcpe_pkg

// Add, mark and clear requests give one result each. A scan request walks the slots
// in order: each empty slot i is skipped, each occupied slot i is read and loaded,
// then each later slot k is visited and, when k is occupied, compared edge by edge
// until an edge misses or all four hit, with an emit step when the pair overlaps;
// the scan ends with one done result. The emit and done steps hold while the output
// register is full and not taken. A single shared add-and-compare unit checks one of
// the four overlap edges per cycle, and the slot memory reads one entry per cycle.
// No request is taken while a scan runs; results wait in one output register.

module rect_collision_pair_engine_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [rcpe_pkg::ALLOW_W-1:0]     i_cfg_wr_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // slot, left, top, width, height, kind, has_callback, zero pad
    input  logic [rcpe_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // func
    input  logic [1:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // first_slot, second_slot, first_notified, second_notified
    output logic [rcpe_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // code
    output logic [2:0]                       m_axis_tuser,
    output logic                             m_axis_tlast
);

    rcpe_pkg::t_state r_state, n_state;

    logic [rcpe_pkg::SLOTS-1:0]   r_valid;
    logic [rcpe_pkg::SLOTS-1:0]   r_pend;
    logic [rcpe_pkg::ALLOW_W-1:0] r_allow;
    logic [rcpe_pkg::CNT_W-1:0]   r_i;
    logic [rcpe_pkg::CNT_W-1:0]   r_k;
    logic [1:0]                   r_step;
    rcpe_pkg::t_entry             r_a;
    rcpe_pkg::t_entry             r_rd_data;
    rcpe_pkg::t_entry             mem [rcpe_pkg::SLOTS];

    logic          r_out_valid;
    rcpe_pkg::t_code r_out_code;
    logic [2:0]    r_out_first;
    logic [2:0]    r_out_second;
    logic          r_out_nf;
    logic          r_out_ns;
    logic          r_out_last;

    rcpe_pkg::t_code n_code;
    logic [2:0]    n_first;
    logic [2:0]    n_second;
    logic          n_nf;
    logic          n_ns;
    logic          n_last;
    logic          out_load;

    logic          out_free;
    logic          in_acc;
    rcpe_pkg::t_func in_func;
    logic [2:0]    in_slot;
    rcpe_pkg::t_entry in_entry;

    logic [rcpe_pkg::SLOT_W-1:0] free_idx;
    logic                        free_found;
    logic                        mark_ok;
    logic [rcpe_pkg::SLOT_W-1:0] rd_addr;
    logic                        i_end;
    logic                        k_end;
    logic                        i_occ;
    logic                        k_occ;

    logic signed [17:0] cmp_p;
    logic signed [17:0] cmp_q;
    logic signed [17:0] cmp_s;
    logic signed [17:0] cmp_sum;
    logic               cmp_hit;

    // request unpacking
    assign in_func          = rcpe_pkg::t_func'(s_axis_tuser);
    assign in_slot          = s_axis_tdata[2:0];
    assign in_entry.left    = s_axis_tdata[18:3];
    assign in_entry.top     = s_axis_tdata[34:19];
    assign in_entry.width   = s_axis_tdata[49:35];
    assign in_entry.height  = s_axis_tdata[64:50];
    assign in_entry.kind    = s_axis_tdata[67:65];
    assign in_entry.cb      = s_axis_tdata[68];

    assign out_free = !r_out_valid || m_axis_tready;
    assign in_acc   = s_axis_tvalid && s_axis_tready;

    assign i_end = (r_i == rcpe_pkg::CNT_W'(rcpe_pkg::SLOTS));
    assign k_end = (r_k == rcpe_pkg::CNT_W'(rcpe_pkg::SLOTS));
    assign i_occ = r_valid[r_i[rcpe_pkg::SLOT_W-1:0]];
    assign k_occ = r_valid[r_k[rcpe_pkg::SLOT_W-1:0]];

    // lowest free slot
    always_comb begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int j = rcpe_pkg::SLOTS - 1; j >= 0; j--) begin
            if (!r_valid[j]) begin
                free_idx   = rcpe_pkg::SLOT_W'(j);
                free_found = 1'b1;
            end
        end
    end

    assign mark_ok = (32'(in_slot) < rcpe_pkg::SLOTS) &&
                     r_valid[in_slot[rcpe_pkg::SLOT_W-1:0]];

    // shared edge compare: p < q + size, one edge per step
    always_comb begin
        case (r_step)
            2'd0: begin
                cmp_p = 18'(signed'(r_a.left));
                cmp_q = 18'(signed'(r_rd_data.left));
                cmp_s = 18'(r_rd_data.width);
            end
            2'd1: begin
                cmp_p = 18'(signed'(r_rd_data.left));
                cmp_q = 18'(signed'(r_a.left));
                cmp_s = 18'(r_a.width);
            end
            2'd2: begin
                cmp_p = 18'(signed'(r_a.top));
                cmp_q = 18'(signed'(r_rd_data.top));
                cmp_s = 18'(r_rd_data.height);
            end
            default: begin
                cmp_p = 18'(signed'(r_rd_data.top));
                cmp_q = 18'(signed'(r_a.top));
                cmp_s = 18'(r_a.height);
            end
        endcase
        cmp_sum = cmp_q + cmp_s;
        cmp_hit = cmp_p < cmp_sum;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rcpe_pkg::S_IDLE: begin
                if (in_acc && in_func == rcpe_pkg::FUNC_SCAN) begin
                    n_state = rcpe_pkg::S_FIND_I;
                end
            end
            rcpe_pkg::S_FIND_I: begin
                if (i_end) begin
                    n_state = rcpe_pkg::S_DONE;
                end else if (i_occ) begin
                    n_state = rcpe_pkg::S_LOAD_A;
                end
            end
            rcpe_pkg::S_LOAD_A: begin
                n_state = rcpe_pkg::S_FIND_K;
            end
            rcpe_pkg::S_FIND_K: begin
                if (k_end) begin
                    n_state = rcpe_pkg::S_FIND_I;
                end else if (k_occ) begin
                    n_state = rcpe_pkg::S_CMP;
                end
            end
            rcpe_pkg::S_CMP: begin
                if (!cmp_hit) begin
                    n_state = rcpe_pkg::S_FIND_K;
                end else if (r_step == 2'd3) begin
                    n_state = rcpe_pkg::S_EMIT;
                end
            end
            rcpe_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = rcpe_pkg::S_FIND_K;
                end
            end
            rcpe_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = rcpe_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rcpe_pkg::S_IDLE;
            end
        endcase
    end

    // outputs and result selection
    always_comb begin
        s_axis_tready = 1'b0;
        rd_addr       = r_k[rcpe_pkg::SLOT_W-1:0];
        out_load      = 1'b0;
        n_code        = rcpe_pkg::CODE_DONE;
        n_first       = 3'd0;
        n_second      = 3'd0;
        n_nf          = 1'b0;
        n_ns          = 1'b0;
        n_last        = 1'b1;
        case (r_state)
            rcpe_pkg::S_IDLE: begin
                s_axis_tready = out_free;
                case (in_func)
                    rcpe_pkg::FUNC_ADD: begin
                        out_load = in_acc;
                        if (free_found) begin
                            n_code  = rcpe_pkg::CODE_ADDED;
                            n_first = 3'(free_idx);
                        end else begin
                            n_code  = rcpe_pkg::CODE_FULL;
                        end
                    end
                    rcpe_pkg::FUNC_MARK: begin
                        out_load = in_acc;
                        n_first  = in_slot;
                        n_code   = mark_ok ? rcpe_pkg::CODE_MARKED : rcpe_pkg::CODE_EMPTY;
                    end
                    rcpe_pkg::FUNC_CLEAR: begin
                        out_load = in_acc;
                        n_code   = rcpe_pkg::CODE_CLEARED;
                    end
                    default: begin
                        out_load = 1'b0;
                    end
                endcase
            end
            rcpe_pkg::S_FIND_I: begin
                rd_addr = r_i[rcpe_pkg::SLOT_W-1:0];
            end
            rcpe_pkg::S_EMIT: begin
                out_load = out_free;
                n_code   = rcpe_pkg::CODE_PAIR;
                n_first  = 3'(r_i);
                n_second = 3'(r_k);
                n_nf     = rcpe_pkg::notify({r_a.cb, r_a.kind},
                                            {r_rd_data.cb, r_rd_data.kind}, r_allow);
                n_ns     = rcpe_pkg::notify({r_rd_data.cb, r_rd_data.kind},
                                            {r_a.cb, r_a.kind}, r_allow);
                n_last   = 1'b0;
            end
            rcpe_pkg::S_DONE: begin
                out_load = out_free;
                n_code   = rcpe_pkg::CODE_DONE;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    // slot memory
    always_ff @(posedge i_clk) begin
        if (in_acc && in_func == rcpe_pkg::FUNC_ADD && free_found) begin
            mem[free_idx] <= in_entry;
        end
        r_rd_data <= mem[rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rcpe_pkg::S_IDLE;
            r_valid     <= '0;
            r_pend      <= '0;
            r_allow     <= rcpe_pkg::ALLOW_RESET;
            r_i         <= '0;
            r_k         <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_allow <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                case (in_func)
                    rcpe_pkg::FUNC_ADD: begin
                        if (free_found) begin
                            r_valid[free_idx] <= 1'b1;
                            r_pend[free_idx]  <= 1'b0;
                        end
                    end
                    rcpe_pkg::FUNC_MARK: begin
                        if (mark_ok) begin
                            r_pend[in_slot[rcpe_pkg::SLOT_W-1:0]] <= 1'b1;
                        end
                    end
                    rcpe_pkg::FUNC_SCAN: begin
                        r_valid <= r_valid & ~r_pend;
                        r_pend  <= '0;
                        r_i     <= '0;
                    end
                    default: begin
                        r_valid <= '0;
                        r_pend  <= '0;
                    end
                endcase
            end
            case (r_state)
                rcpe_pkg::S_FIND_I: begin
                    if (!i_end) begin
                        if (i_occ) begin
                            r_k <= r_i + rcpe_pkg::CNT_W'(1);
                        end else begin
                            r_i <= r_i + rcpe_pkg::CNT_W'(1);
                        end
                    end
                end
                rcpe_pkg::S_FIND_K: begin
                    if (k_end) begin
                        r_i <= r_i + rcpe_pkg::CNT_W'(1);
                    end else if (k_occ) begin
                        r_step <= 2'd0;
                    end else begin
                        r_k <= r_k + rcpe_pkg::CNT_W'(1);
                    end
                end
                rcpe_pkg::S_CMP: begin
                    if (!cmp_hit) begin
                        r_k <= r_k + rcpe_pkg::CNT_W'(1);
                    end else begin
                        r_step <= r_step + 2'd1;
                    end
                end
                rcpe_pkg::S_EMIT: begin
                    if (out_free) begin
                        r_k <= r_k + rcpe_pkg::CNT_W'(1);
                    end
                end
                default: begin
                    r_step <= r_step;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == rcpe_pkg::S_LOAD_A) begin
            r_a <= r_rd_data;
        end
        if (out_load) begin
            r_out_code   <= n_code;
            r_out_first  <= n_first;
            r_out_second <= n_second;
            r_out_nf     <= n_nf;
            r_out_ns     <= n_ns;
            r_out_last   <= n_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_ns, r_out_nf, r_out_second, r_out_first};
    assign m_axis_tuser  = r_out_code;
    assign m_axis_tlast  = r_out_last;

endmodule

### tb/sv/rect_collision_pair_engine_top_tb.sv
// self-checking testbench for the rectangle pair engine: directed, permission mask and random
// traffic with a built-in table predictor, depends on rcpe_pkg and rect_collision_pair_engine_top
`timescale 1ns / 100ps

module rect_collision_pair_engine_top_tb;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        rcpe_pkg::t_code code;
        logic [2:0] first_slot;
        logic [2:0] second_slot;
        logic       first_notified;
        logic       second_notified;
        logic       last;
    } t_pair_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [rcpe_pkg::ALLOW_W-1:0] i_cfg_wr_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [rcpe_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [rcpe_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;
    logic m_axis_tlast;

    // table model
    logic [rcpe_pkg::ALLOW_W-1:0] model_allow;
    logic model_valid [rcpe_pkg::SLOTS];
    logic model_marked [rcpe_pkg::SLOTS];
    rcpe_pkg::t_entry model_rect [rcpe_pkg::SLOTS];
    t_pair_result pending_results [$];

    int fail_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int quiet_cycles = 0;
    t_pair_result seen_exp;

    rect_collision_pair_engine_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic logic rects_overlap(input rcpe_pkg::t_entry a,
                                           input rcpe_pkg::t_entry b);
        int ax, ay, aw, ah, bx, by, bw, bh;
        ax = int'($signed(a.left));
        ay = int'($signed(a.top));
        aw = int'(a.width);
        ah = int'(a.height);
        bx = int'($signed(b.left));
        by = int'($signed(b.top));
        bw = int'(b.width);
        bh = int'(b.height);
        return (ax < bx + bw) && (ax + aw > bx) && (ay < by + bh) && (ay + ah > by);
    endfunction

    function automatic logic side_notified(input rcpe_pkg::t_entry self_r,
                                           input rcpe_pkg::t_entry other_r);
        if (!self_r.cb || self_r.kind > 3'd4 || other_r.kind > 3'd4) begin
            return 1'b0;
        end
        return model_allow[int'(self_r.kind) * rcpe_pkg::KINDS + int'(other_r.kind)];
    endfunction

    function automatic t_pair_result make_result(input rcpe_pkg::t_code code,
                                                 input logic [2:0] a,
                                                 input logic [2:0] b, input logic na,
                                                 input logic nb, input logic last);
        t_pair_result r;
        r.code = code;
        r.first_slot = a;
        r.second_slot = b;
        r.first_notified = na;
        r.second_notified = nb;
        r.last = last;
        return r;
    endfunction

    task automatic predict_request(input rcpe_pkg::t_func f, input logic [2:0] slot,
                                   input rcpe_pkg::t_entry e);
        int free_slot;
        free_slot = -1;
        case (f)
            rcpe_pkg::FUNC_ADD: begin
                for (int i = rcpe_pkg::SLOTS - 1; i >= 0; i--) begin
                    if (!model_valid[i]) free_slot = i;
                end
                if (free_slot < 0) begin
                    pending_results.push_back(make_result(rcpe_pkg::CODE_FULL, 3'd0, 3'd0,
                                                          1'b0, 1'b0, 1'b1));
                end else begin
                    model_valid[free_slot] = 1'b1;
                    model_marked[free_slot] = 1'b0;
                    model_rect[free_slot] = e;
                    pending_results.push_back(make_result(rcpe_pkg::CODE_ADDED,
                                                          3'(free_slot), 3'd0,
                                                          1'b0, 1'b0, 1'b1));
                end
            end
            rcpe_pkg::FUNC_MARK: begin
                if (int'(slot) < rcpe_pkg::SLOTS && model_valid[slot]) begin
                    model_marked[slot] = 1'b1;
                    pending_results.push_back(make_result(rcpe_pkg::CODE_MARKED, slot, 3'd0,
                                                          1'b0, 1'b0, 1'b1));
                end else begin
                    pending_results.push_back(make_result(rcpe_pkg::CODE_EMPTY, slot, 3'd0,
                                                          1'b0, 1'b0, 1'b1));
                end
            end
            rcpe_pkg::FUNC_CLEAR: begin
                for (int i = 0; i < rcpe_pkg::SLOTS; i++) begin
                    model_valid[i] = 1'b0;
                    model_marked[i] = 1'b0;
                end
                pending_results.push_back(make_result(rcpe_pkg::CODE_CLEARED, 3'd0, 3'd0,
                                                      1'b0, 1'b0, 1'b1));
            end
            default: begin
                for (int i = 0; i < rcpe_pkg::SLOTS; i++) begin
                    if (model_marked[i]) model_valid[i] = 1'b0;
                    model_marked[i] = 1'b0;
                end
                for (int i = 0; i < rcpe_pkg::SLOTS; i++) begin
                    for (int k = i + 1; k < rcpe_pkg::SLOTS; k++) begin
                        if (model_valid[i] && model_valid[k] &&
                            rects_overlap(model_rect[i], model_rect[k])) begin
                            pending_results.push_back(make_result(
                                rcpe_pkg::CODE_PAIR, 3'(i), 3'(k),
                                side_notified(model_rect[i], model_rect[k]),
                                side_notified(model_rect[k], model_rect[i]), 1'b0));
                        end
                    end
                end
                pending_results.push_back(make_result(rcpe_pkg::CODE_DONE, 3'd0, 3'd0,
                                                      1'b0, 1'b0, 1'b1));
            end
        endcase
    endtask

    // called at a rising edge, returns at the edge that takes the request
    task automatic send_request(input rcpe_pkg::t_func f, input logic [2:0] slot,
                                input rcpe_pkg::t_entry e);
        logic taken;
        taken = 1'b0;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, e.cb, e.kind, e.height, e.width, e.top, e.left, slot};
        s_axis_tuser <= f;
        while (!taken) begin
            @(negedge i_clk);
            taken = s_axis_tready;
            if (taken) predict_request(f, slot, e);
            @(posedge i_clk);
        end
    endtask

    function automatic rcpe_pkg::t_entry make_rect(input int x, input int y, input int w,
                                                   input int h, input int kind,
                                                   input logic cb);
        rcpe_pkg::t_entry e;
        e.left = 16'(x);
        e.top = 16'(y);
        e.width = 15'(w);
        e.height = 15'(h);
        e.kind = 3'(kind);
        e.cb = cb;
        return e;
    endfunction

    function automatic rcpe_pkg::t_entry rand_rect();
        rcpe_pkg::t_entry e;
        if ($urandom_range(0, 4) == 0) begin
            e = rcpe_pkg::t_entry'({2'($urandom), $urandom, $urandom});
        end else begin
            e = make_rect(int'($urandom_range(0, 200)) - 100, int'($urandom_range(0, 200)) - 100,
                          $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 120),
                          $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 120),
                          $urandom_range(0, 7) == 0 ? $urandom_range(5, 7) : $urandom_range(0, 4),
                          1'($urandom_range(0, 1)));
        end
        return e;
    endfunction

    task automatic add_rect(input rcpe_pkg::t_entry e);
        send_request(rcpe_pkg::FUNC_ADD, 3'($urandom), e);
    endtask

    task automatic mark_slot(input logic [2:0] slot);
        send_request(rcpe_pkg::FUNC_MARK, slot, rand_rect());
    endtask

    task automatic scan_table();
        send_request(rcpe_pkg::FUNC_SCAN, 3'($urandom), rand_rect());
    endtask

    task automatic clear_table();
        send_request(rcpe_pkg::FUNC_CLEAR, 3'($urandom), rand_rect());
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_allow(input logic [rcpe_pkg::ALLOW_W-1:0] mask);
        wait_drained();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= mask;
        @(posedge i_clk);
        model_allow = mask;
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic test_directed_table();
        clear_table();
        scan_table();
        add_rect(make_rect(-32768, -32768, 32767, 32767, 1, 1'b1));
        add_rect(make_rect(-100, -100, 200, 200, 3, 1'b1));
        // touches the previous one on its right edge only
        add_rect(make_rect(100, -100, 50, 50, 2, 1'b0));
        add_rect(make_rect(0, 0, 0, 50, 4, 1'b1));
        add_rect(make_rect(32767, 32767, 32767, 32767, 7, 1'b1));
        add_rect(make_rect(32000, 32000, 1000, 1000, 0, 1'b1));
        add_rect(make_rect(-10, -10, 20, 20, 2, 1'b1));
        add_rect(make_rect(-20, -20, 40, 0, 6, 1'b0));
        add_rect(make_rect(-20, -20, 40, 40, 5, 1'b1));
        scan_table();
        mark_slot(3'd1);
        mark_slot(3'd1);
        add_rect(make_rect(1, 1, 1, 1, 1, 1'b1));
        scan_table();
        mark_slot(3'd1);
        add_rect(make_rect(-5, -5, 10, 10, 4, 1'b1));
        scan_table();
        mark_slot(3'd7);
        clear_table();
        mark_slot(3'd0);
        scan_table();
    endtask

    task automatic test_allow_extremes();
        logic [rcpe_pkg::ALLOW_W-1:0] masks [3];
        masks[0] = '0;
        masks[1] = '1;
        masks[2] = rcpe_pkg::ALLOW_W'(25'h0AAAAAA);
        foreach (masks[m]) begin
            write_allow(masks[m]);
            clear_table();
            for (int kind = 0; kind < rcpe_pkg::KINDS; kind++) begin
                add_rect(make_rect(kind * 3, kind * 3, 10, 10, kind, 1'b1));
            end
            scan_table();
        end
    endtask

    task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
        int pick;
        write_allow(rcpe_pkg::ALLOW_W'($urandom));
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) add_rect(rand_rect());
            else if (pick < 68) mark_slot(3'($urandom));
            else if (pick < 94) scan_table();
            else clear_table();
        end
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: code %0d", m_axis_tuser);
                fail_count++;
            end else begin
                seen_exp = pending_results.pop_front();
                if (m_axis_tuser !== seen_exp.code) begin
                    $error("code: expected %0d, got %0d", seen_exp.code, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[2:0] !== seen_exp.first_slot) begin
                    $error("first_slot: expected %0d, got %0d", seen_exp.first_slot,
                           m_axis_tdata[2:0]);
                    fail_count++;
                end
                if (m_axis_tdata[5:3] !== seen_exp.second_slot) begin
                    $error("second_slot: expected %0d, got %0d", seen_exp.second_slot,
                           m_axis_tdata[5:3]);
                    fail_count++;
                end
                if (m_axis_tdata[6] !== seen_exp.first_notified) begin
                    $error("first_notified: expected %0b, got %0b", seen_exp.first_notified,
                           m_axis_tdata[6]);
                    fail_count++;
                end
                if (m_axis_tdata[7] !== seen_exp.second_notified) begin
                    $error("second_notified: expected %0b, got %0b", seen_exp.second_notified,
                           m_axis_tdata[7]);
                    fail_count++;
                end
                if (m_axis_tlast !== seen_exp.last) begin
                    $error("last: expected %0b, got %0b", seen_exp.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        model_allow = rcpe_pkg::ALLOW_RESET;
        for (int i = 0; i < rcpe_pkg::SLOTS; i++) begin
            model_valid[i] = 1'b0;
            model_marked[i] = 1'b0;
            model_rect[i] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_table();
        test_allow_extremes();
        test_random_traffic(55, 31, 68);
        test_random_traffic(55, 68, 31);
        test_random_traffic(55, 0, 0);
        wait_drained();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
